// ----- hw/rtl/xric_pkg.sv -----
package xric_pkg;

    localparam int NUM_BYTE_SLOTS = 16;   // instruction byte positions an opcode can sit at
    localparam int BYTE_ARR_DEPTH = 18;   // slots plus two look-ahead bytes past the last one

    typedef logic [7:0] byte_t;
    typedef logic [4:0] count_t;

    localparam byte_t NO_BYTE     = 8'hFF;
    localparam byte_t OP_ESCAPE   = 8'h0F;
    localparam byte_t ESC_GRP7    = 8'h01;
    localparam byte_t ESC_MOV_RCR = 8'h20;
    localparam byte_t ESC_MOV_CRR = 8'h22;
    localparam byte_t OP_JCC_LO   = 8'h70;
    localparam byte_t OP_JCC_HI   = 8'h7F;
    localparam byte_t OP_LOOP_LO  = 8'hE0;
    localparam byte_t OP_JCXZ     = 8'hE3;
    localparam byte_t OP_IN_IB    = 8'hE4;
    localparam byte_t OP_IN_IV    = 8'hE5;
    localparam byte_t OP_OUT_IB   = 8'hE6;
    localparam byte_t OP_OUT_IV   = 8'hE7;
    localparam byte_t OP_JMP_NEAR = 8'hE9;
    localparam byte_t OP_JMP_FAR  = 8'hEA;
    localparam byte_t OP_JMP_SHRT = 8'hEB;
    localparam byte_t OP_IN_DB    = 8'hEC;
    localparam byte_t OP_IN_DV    = 8'hED;
    localparam byte_t OP_OUT_DB   = 8'hEE;
    localparam byte_t OP_OUT_DV   = 8'hEF;
    localparam byte_t OP_GRP5     = 8'hFF;

    localparam logic [1:0] FORM_NONE = 2'd0;
    localparam logic [1:0] FORM_REG  = 2'd1;
    localparam logic [1:0] FORM_MEM  = 2'd2;

    localparam logic [3:0] MODRM_REG_NONE = 4'd8;

    localparam logic [1:0] CTL_NONE  = 2'd0;
    localparam logic [1:0] CTL_FALL  = 2'd1;
    localparam logic [1:0] CTL_TAKEN = 2'd2;

    localparam logic [1:0] IO_NONE = 2'd0;
    localparam logic [1:0] IO_IN   = 2'd1;
    localparam logic [1:0] IO_OUT  = 2'd2;

    localparam logic [2:0] IO_BYTES_0 = 3'd0;
    localparam logic [2:0] IO_BYTES_1 = 3'd1;
    localparam logic [2:0] IO_BYTES_2 = 3'd2;
    localparam logic [2:0] IO_BYTES_4 = 3'd4;

    function automatic logic is_prefix(input byte_t b);
        logic r;
        begin
            case (b)
                8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65,
                8'h66, 8'h67, 8'hF0, 8'hF2, 8'hF3: r = 1'b1;
                default: r = 1'b0;
            endcase
            return r;
        end
    endfunction

    function automatic logic has_modrm(input byte_t op);
        logic r;
        begin
            r = ((op <= 8'h3B) && (op[2:0] <= 3'd3)) ||
                (op >= 8'h80 && op <= 8'h8F) ||
                (op >= 8'hC4 && op <= 8'hC7) ||
                (op >= 8'hD0 && op <= 8'hD3) ||
                op == 8'hF6 || op == 8'hF7 || op == 8'hFE || op == 8'hFF;
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/x86_retired_instruction_classifier.sv -----
// Channel | Handshake             | Beat contents
// in      | in_valid / in_stall   | instruction bytes, sizes, prefixes, IPs, DX, EAX
// out     | out_valid / out_stall | prefix count, opcodes, ModRM, branch outcome, IO decode
//
// One beat per clock while out_stall is low; each beat passes the input register, then the result register.
// All decode sits between those two registers: byte-parallel prefix detect, priority
// pick of the opcode slot, and one 32-bit add and compare for the fallthrough check.
// rst_n clears both valid flags only. A stalled result holds; in_stall rises only while
// both registers hold a beat and out_stall is high.
module x86_retired_instruction_classifier #(
    parameter int MAX_INSTRUCTION_BYTES = 15
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] bytes_low,
    input  logic [55:0] bytes_high,
    input  logic [3:0]  instr_len,
    input  logic        default_size_32,
    input  logic        operand_prefix,
    input  logic        address_prefix,
    input  logic [31:0] old_ip,
    input  logic        old_default_size_32,
    input  logic [31:0] new_ip,
    input  logic [3:0]  body_length,
    input  logic [15:0] dx_value,
    input  logic [31:0] accumulator,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  prefix_count,
    output logic [7:0]  opcode,
    output logic [7:0]  ext_opcode,
    output logic [1:0]  modrm_mode,
    output logic [3:0]  modrm_reg,
    output logic [1:0]  branch_status,
    output logic [1:0]  io_dir,
    output logic [15:0] io_port,
    output logic [2:0]  io_width,
    output logic [31:0] io_data,
    output logic        opsize_32,
    output logic        addrsize_32
);

    import xric_pkg::*;

    localparam count_t MAX_BYTES = count_t'(MAX_INSTRUCTION_BYTES);

    // input register
    logic        s1_valid_reg;
    logic [63:0] bytes_low_reg;
    logic [55:0] bytes_high_reg;
    logic [3:0]  byte_count_reg;
    logic        dsz_reg;
    logic        opp_reg;
    logic        adp_reg;
    logic [31:0] old_ip_reg;
    logic        old_dsz_reg;
    logic [31:0] new_ip_reg;
    logic [3:0]  body_reg;
    logic [15:0] dx_reg;
    logic [31:0] acc_reg;

    // result register
    logic        out_valid_reg;
    logic [3:0]  pc_reg,    pc_next;
    byte_t       op_reg,    op_next;
    byte_t       esc_reg,   esc_next;
    logic [1:0]  form_reg,  form_next;
    logic [3:0]  mreg_reg,  mreg_next;
    logic [1:0]  ctl_reg,   ctl_next;
    logic [1:0]  iodir_reg, iodir_next;
    logic [15:0] ioport_reg, ioport_next;
    logic [2:0]  iobytes_reg, iobytes_next;
    logic [31:0] ioval_reg, ioval_next;
    logic        osz_reg,   osz_next;
    logic        asz_reg,   asz_next;

    logic out_busy;
    assign out_busy = out_valid_reg && out_stall;
    assign in_stall = s1_valid_reg && out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!out_busy)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            bytes_low_reg  <= bytes_low;
            bytes_high_reg <= bytes_high;
            byte_count_reg <= instr_len;
            dsz_reg        <= default_size_32;
            opp_reg        <= operand_prefix;
            adp_reg        <= address_prefix;
            old_ip_reg     <= old_ip;
            old_dsz_reg    <= old_default_size_32;
            new_ip_reg     <= new_ip;
            body_reg       <= body_length;
            dx_reg         <= dx_value;
            acc_reg        <= accumulator;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && !out_busy)
        begin
            pc_reg      <= pc_next;
            op_reg      <= op_next;
            esc_reg     <= esc_next;
            form_reg    <= form_next;
            mreg_reg    <= mreg_next;
            ctl_reg     <= ctl_next;
            iodir_reg   <= iodir_next;
            ioport_reg  <= ioport_next;
            iobytes_reg <= iobytes_next;
            ioval_reg   <= ioval_next;
            osz_reg     <= osz_next;
            asz_reg     <= asz_next;
        end
    end

    // decode
    byte_t                     byte_arr [BYTE_ARR_DEPTH];
    logic [NUM_BYTE_SLOTS-1:0] stop;
    logic [NUM_BYTE_SLOTS-1:0] sel;
    count_t                    cnt;
    byte_t                     op_raw;
    byte_t                     nxt1;
    byte_t                     nxt2;
    byte_t                     modrm;
    logic                      op_ok;
    logic                      nxt1_ok;
    logic                      nxt2_ok;
    logic                      modrm_ok;
    logic                      is_cond;
    logic [31:0]               ft_sum;
    logic [31:0]               ft_addr;
    logic                      io_hit;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_arr[i] = bytes_low_reg[8*i +: 8];
        end
        for (int i = 0; i < 7; i++)
        begin
            byte_arr[8+i] = bytes_high_reg[8*i +: 8];
        end
        for (int i = 15; i < BYTE_ARR_DEPTH; i++)
        begin
            byte_arr[i] = 8'h00;
        end
    end

    always_comb
    begin
        cnt = (count_t'(byte_count_reg) > MAX_BYTES) ? MAX_BYTES : count_t'(byte_count_reg);

        // scan ends at the first slot that is past the count or not a prefix
        for (int i = 0; i < NUM_BYTE_SLOTS; i++)
        begin
            stop[i] = (count_t'(i) >= cnt) || !is_prefix(byte_arr[i]);
        end
        pc_next = 4'(NUM_BYTE_SLOTS - 1);
        for (int i = NUM_BYTE_SLOTS - 1; i >= 0; i--)
        begin
            if (stop[i])
            begin
                pc_next = 4'(i);
            end
        end
        for (int i = 0; i < NUM_BYTE_SLOTS; i++)
        begin
            sel[i] = (pc_next == 4'(i));
        end

        op_raw = 8'h00;
        nxt1   = 8'h00;
        nxt2   = 8'h00;
        for (int i = 0; i < NUM_BYTE_SLOTS; i++)
        begin
            op_raw = op_raw | (byte_arr[i]   & {8{sel[i]}});
            nxt1   = nxt1   | (byte_arr[i+1] & {8{sel[i]}});
            nxt2   = nxt2   | (byte_arr[i+2] & {8{sel[i]}});
        end

        op_ok   = count_t'(pc_next) < cnt;
        nxt1_ok = (count_t'(pc_next) + 5'd1) < cnt;
        nxt2_ok = (count_t'(pc_next) + 5'd2) < cnt;

        op_next  = op_ok ? op_raw : NO_BYTE;
        esc_next = (op_ok && op_raw == OP_ESCAPE && nxt1_ok) ? nxt1 : NO_BYTE;

        if (op_raw == OP_ESCAPE)
        begin
            modrm    = nxt2;
            modrm_ok = nxt2_ok && (nxt1 == ESC_GRP7 || nxt1 == ESC_MOV_RCR ||
                                   nxt1 == ESC_MOV_CRR);
        end
        else
        begin
            modrm    = nxt1;
            modrm_ok = nxt1_ok && has_modrm(op_raw);
        end
        modrm_ok = modrm_ok && op_ok;
        if (modrm_ok)
        begin
            form_next = (modrm[7:6] == 2'b11) ? FORM_REG : FORM_MEM;
            mreg_next = {1'b0, modrm[5:3]};
        end
        else
        begin
            form_next = FORM_NONE;
            mreg_next = MODRM_REG_NONE;
        end

        // fallthrough target, wrapped to 16 bits in 16-bit code
        ft_sum  = old_ip_reg + 32'(pc_next) + 32'(body_reg);
        ft_addr = old_dsz_reg ? ft_sum : {16'h0000, ft_sum[15:0]};
        is_cond = (op_raw >= OP_JCC_LO && op_raw <= OP_JCC_HI) ||
                  (op_raw >= OP_LOOP_LO && op_raw <= OP_JCXZ);
        ctl_next = CTL_NONE;
        if (op_ok)
        begin
            if (is_cond)
            begin
                if (body_reg != 4'd0)
                begin
                    ctl_next = (new_ip_reg == ft_addr) ? CTL_FALL : CTL_TAKEN;
                end
            end
            else if (op_raw == OP_JMP_NEAR || op_raw == OP_JMP_FAR ||
                     op_raw == OP_JMP_SHRT || op_raw == OP_GRP5)
            begin
                ctl_next = CTL_TAKEN;
            end
        end

        osz_next = dsz_reg ^ opp_reg;
        asz_next = dsz_reg ^ adp_reg;

        // immediate-port forms need the port byte inside the valid bytes
        iodir_next   = IO_NONE;
        ioport_next  = 16'h0000;
        iobytes_next = IO_BYTES_0;
        ioval_next   = 32'h0000_0000;
        io_hit       = 1'b0;
        if (op_ok && op_raw >= OP_IN_IB && op_raw <= OP_OUT_IV && nxt1_ok)
        begin
            io_hit      = 1'b1;
            ioport_next = {8'h00, nxt1};
        end
        else if (op_ok && op_raw >= OP_IN_DB && op_raw <= OP_OUT_DV)
        begin
            io_hit      = 1'b1;
            ioport_next = dx_reg;
        end
        if (io_hit)
        begin
            iodir_next = (op_raw == OP_IN_IB || op_raw == OP_IN_IV ||
                          op_raw == OP_IN_DB || op_raw == OP_IN_DV) ? IO_IN : IO_OUT;
            if (op_raw == OP_IN_IB || op_raw == OP_OUT_IB ||
                op_raw == OP_IN_DB || op_raw == OP_OUT_DB)
            begin
                iobytes_next = IO_BYTES_1;
                ioval_next   = {24'h000000, acc_reg[7:0]};
            end
            else if (osz_next)
            begin
                iobytes_next = IO_BYTES_4;
                ioval_next   = acc_reg;
            end
            else
            begin
                iobytes_next = IO_BYTES_2;
                ioval_next   = {16'h0000, acc_reg[15:0]};
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign prefix_count  = pc_reg;
    assign opcode        = op_reg;
    assign ext_opcode    = esc_reg;
    assign modrm_mode    = form_reg;
    assign modrm_reg     = mreg_reg;
    assign branch_status = ctl_reg;
    assign io_dir        = iodir_reg;
    assign io_port       = ioport_reg;
    assign io_width      = iobytes_reg;
    assign io_data       = ioval_reg;
    assign opsize_32     = osz_reg;
    assign addrsize_32   = asz_reg;

endmodule

// ----- tb/x86_retired_instruction_classifier_tb.sv -----
module x86_retired_instruction_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xric_pkg::*;

    localparam int MAX_BYTES    = 15;
    localparam int NUM_RANDOM   = 750;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // legacy prefixes
    localparam byte_t PFX_ES    = 8'h26;
    localparam byte_t PFX_CS    = 8'h2E;
    localparam byte_t PFX_SS    = 8'h36;
    localparam byte_t PFX_DS    = 8'h3E;
    localparam byte_t PFX_FS    = 8'h64;
    localparam byte_t PFX_GS    = 8'h65;
    localparam byte_t PFX_OPSZ  = 8'h66;
    localparam byte_t PFX_ADSZ  = 8'h67;
    localparam byte_t PFX_LOCK  = 8'hF0;
    localparam byte_t PFX_REPNE = 8'hF2;
    localparam byte_t PFX_REP   = 8'hF3;

    // opcode groups that carry a ModRM byte
    localparam byte_t OP_ADD_EB_GB  = 8'h00;
    localparam byte_t OP_ALU_LAST   = 8'h3B;
    localparam byte_t OP_GRP1       = 8'h80;
    localparam byte_t OP_POP_EV     = 8'h8F;
    localparam byte_t OP_LES        = 8'hC4;
    localparam byte_t OP_MOV_EV_IV  = 8'hC7;
    localparam byte_t OP_SHIFT_LO   = 8'hD0;
    localparam byte_t OP_SHIFT_HI   = 8'hD3;
    localparam byte_t OP_GRP3_B     = 8'hF6;
    localparam byte_t OP_GRP3_V     = 8'hF7;
    localparam byte_t OP_GRP4       = 8'hFE;
    localparam byte_t ESC_CPUID     = 8'hA2;

    localparam byte_t MODRM_REG_EAX = 8'hC0;
    localparam byte_t MODRM_MEM_DSP = 8'h15;

    typedef struct packed {
        logic [63:0] bytes_low;
        logic [55:0] bytes_high;
        logic [3:0]  instr_len;
        logic        default_size_32;
        logic        operand_prefix;
        logic        address_prefix;
        logic [31:0] old_ip;
        logic        old_default_size_32;
        logic [31:0] new_ip;
        logic [3:0]  body_length;
        logic [15:0] dx_value;
        logic [31:0] accumulator;
    } instr_beat_t;

    typedef struct packed {
        logic [3:0]  prefix_count;
        logic [7:0]  opcode;
        logic [7:0]  ext_opcode;
        logic [1:0]  modrm_mode;
        logic [3:0]  modrm_reg;
        logic [1:0]  branch_status;
        logic [1:0]  io_dir;
        logic [15:0] io_port;
        logic [2:0]  io_width;
        logic [31:0] io_data;
        logic        opsize_32;
        logic        addrsize_32;
    } decode_t;

    class decode_checker;
        decode_t expected_decodes[$];
        int      mismatches;
        int      decodes_seen;

        function bit legacy_prefix(byte_t v);
            case (v)
                PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
                PFX_OPSZ, PFX_ADSZ, PFX_LOCK, PFX_REPNE, PFX_REP: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function bit takes_modrm(byte_t v);
            if (v <= OP_ALU_LAST)
                return v[2:0] < 3'd4;
            return (v >= OP_GRP1 && v <= OP_POP_EV) || (v >= OP_LES && v <= OP_MOV_EV_IV) ||
                   (v >= OP_SHIFT_LO && v <= OP_SHIFT_HI) || v == OP_GRP3_B ||
                   v == OP_GRP3_V || v == OP_GRP4 || v == OP_GRP5;
        endfunction

        function decode_t classify(instr_beat_t b);
            byte_t       ib [16];
            int          cnt;
            int          pc;
            int          mpos;
            byte_t       op;
            byte_t       m;
            logic        osz;
            logic [31:0] ft;
            decode_t     r;
            for (int i = 0; i < 8; i++)
                ib[i] = b.bytes_low[8*i +: 8];
            for (int i = 0; i < 7; i++)
                ib[8+i] = b.bytes_high[8*i +: 8];
            ib[15] = '0;
            cnt = int'(b.instr_len);
            if (cnt > MAX_BYTES)
                cnt = MAX_BYTES;
            osz = b.default_size_32 ^ b.operand_prefix;
            r = '0;
            r.opcode        = NO_BYTE;
            r.ext_opcode    = NO_BYTE;
            r.modrm_mode    = FORM_NONE;
            r.modrm_reg     = MODRM_REG_NONE;
            r.branch_status = CTL_NONE;
            r.io_dir        = IO_NONE;
            r.io_width      = IO_BYTES_0;
            r.opsize_32     = osz;
            r.addrsize_32   = b.default_size_32 ^ b.address_prefix;
            pc = 0;
            while (pc < cnt && legacy_prefix(ib[pc]))
                pc++;
            r.prefix_count = pc[3:0];
            if (pc >= cnt)
                return r;
            op = ib[pc];
            r.opcode = op;
            mpos = -1;
            if (op == OP_ESCAPE) begin
                if (pc + 1 < cnt)
                    r.ext_opcode = ib[pc+1];
                if (pc + 2 < cnt && (r.ext_opcode == ESC_GRP7 ||
                    r.ext_opcode == ESC_MOV_RCR || r.ext_opcode == ESC_MOV_CRR))
                    mpos = pc + 2;
            end
            else if (takes_modrm(op) && pc + 1 < cnt)
                mpos = pc + 1;
            if (mpos >= 0) begin
                m = ib[mpos];
                r.modrm_mode = (m[7:6] == 2'b11) ? FORM_REG : FORM_MEM;
                r.modrm_reg  = {1'b0, m[5:3]};
            end
            if ((op >= OP_JCC_LO && op <= OP_JCC_HI) || (op >= OP_LOOP_LO && op <= OP_JCXZ)) begin
                if (b.body_length != 4'd0) begin
                    ft = b.old_ip + 32'(pc) + 32'(b.body_length);
                    if (!b.old_default_size_32)
                        ft[31:16] = '0;
                    r.branch_status = (b.new_ip == ft) ? CTL_FALL : CTL_TAKEN;
                end
            end
            else if (op == OP_JMP_NEAR || op == OP_JMP_FAR || op == OP_JMP_SHRT || op == OP_GRP5)
                r.branch_status = CTL_TAKEN;
            // bit 1 of the IO opcodes selects OUT, bit 0 selects word/dword width
            if ((op >= OP_IN_IB && op <= OP_OUT_IV && pc + 1 < cnt) ||
                (op >= OP_IN_DB && op <= OP_OUT_DV)) begin
                r.io_port  = (op >= OP_IN_DB) ? b.dx_value : {8'h00, ib[pc+1]};
                r.io_dir   = op[1] ? IO_OUT : IO_IN;
                r.io_width = !op[0] ? IO_BYTES_1 : (osz ? IO_BYTES_4 : IO_BYTES_2);
                case (r.io_width)
                    IO_BYTES_1: r.io_data = {24'h0, b.accumulator[7:0]};
                    IO_BYTES_2: r.io_data = {16'h0, b.accumulator[15:0]};
                    default:    r.io_data = b.accumulator;
                endcase
            end
            return r;
        endfunction

        function void note_instruction(instr_beat_t b);
            expected_decodes.push_back(classify(b));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("%0t ns: decode %0d: %s", $time, decodes_seen, msg);
        endtask

        task cmp(string name, logic [31:0] got_v, logic [31:0] exp_v);
            if (got_v !== exp_v)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got_v, exp_v));
        endtask

        task check_decode(decode_t got);
            decode_t e;
            if (expected_decodes.size() == 0) begin
                report_mismatch("result beat with no instruction pending");
                return;
            end
            e = expected_decodes.pop_front();
            cmp("prefix_count", 32'(got.prefix_count), 32'(e.prefix_count));
            cmp("opcode", 32'(got.opcode), 32'(e.opcode));
            cmp("ext_opcode", 32'(got.ext_opcode), 32'(e.ext_opcode));
            cmp("modrm_mode", 32'(got.modrm_mode), 32'(e.modrm_mode));
            cmp("modrm_reg", 32'(got.modrm_reg), 32'(e.modrm_reg));
            cmp("branch_status", 32'(got.branch_status), 32'(e.branch_status));
            cmp("io_dir", 32'(got.io_dir), 32'(e.io_dir));
            cmp("io_port", 32'(got.io_port), 32'(e.io_port));
            cmp("io_width", 32'(got.io_width), 32'(e.io_width));
            cmp("io_data", got.io_data, e.io_data);
            cmp("opsize_32", 32'(got.opsize_32), 32'(e.opsize_32));
            cmp("addrsize_32", 32'(got.addrsize_32), 32'(e.addrsize_32));
            decodes_seen++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall;
    instr_beat_t drive_beat;
    decode_t     seen_decode;

    decode_checker checker_h;
    instr_beat_t   stim_q[$];
    int            beats_sent;
    int            cycle_count;
    bit            hold_done;

    x86_retired_instruction_classifier u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .bytes_low           (drive_beat.bytes_low),
        .bytes_high          (drive_beat.bytes_high),
        .instr_len           (drive_beat.instr_len),
        .default_size_32     (drive_beat.default_size_32),
        .operand_prefix      (drive_beat.operand_prefix),
        .address_prefix      (drive_beat.address_prefix),
        .old_ip              (drive_beat.old_ip),
        .old_default_size_32 (drive_beat.old_default_size_32),
        .new_ip              (drive_beat.new_ip),
        .body_length         (drive_beat.body_length),
        .dx_value            (drive_beat.dx_value),
        .accumulator         (drive_beat.accumulator),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .prefix_count        (seen_decode.prefix_count),
        .opcode              (seen_decode.opcode),
        .ext_opcode          (seen_decode.ext_opcode),
        .modrm_mode          (seen_decode.modrm_mode),
        .modrm_reg           (seen_decode.modrm_reg),
        .branch_status       (seen_decode.branch_status),
        .io_dir              (seen_decode.io_dir),
        .io_port             (seen_decode.io_port),
        .io_width            (seen_decode.io_width),
        .io_data             (seen_decode.io_data),
        .opsize_32           (seen_decode.opsize_32),
        .addrsize_32         (seen_decode.addrsize_32)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            checker_h.check_decode(seen_decode);
    end

    function automatic byte_t pick_prefix();
        case ($urandom_range(0, 10))
            0: return PFX_ES;
            1: return PFX_CS;
            2: return PFX_SS;
            3: return PFX_DS;
            4: return PFX_FS;
            5: return PFX_GS;
            6: return PFX_OPSZ;
            7: return PFX_ADSZ;
            8: return PFX_LOCK;
            9: return PFX_REPNE;
            default: return PFX_REP;
        endcase
    endfunction

    function automatic instr_beat_t rand_fields();
        instr_beat_t b;
        logic [63:0] w;
        w = {$urandom, $urandom};
        b.bytes_low = {$urandom, $urandom};
        b.bytes_high = w[55:0];
        b.instr_len = 4'($urandom_range(0, 15));
        b.default_size_32 = 1'($urandom_range(0, 1));
        b.operand_prefix = 1'($urandom_range(0, 1));
        b.address_prefix = 1'($urandom_range(0, 1));
        b.old_ip = $urandom;
        b.old_default_size_32 = 1'($urandom_range(0, 1));
        b.new_ip = $urandom;
        b.body_length = 4'($urandom_range(0, 15));
        b.dx_value = 16'($urandom_range(0, 65535));
        b.accumulator = $urandom;
        return b;
    endfunction

    // prefixes at 0..at-1, then op and two following bytes; the rest stays random
    function automatic instr_beat_t place(instr_beat_t b, int at, byte_t op, byte_t nxt,
                                          byte_t nxt2, int cnt);
        byte_t ib [15];
        for (int i = 0; i < 8; i++)
            ib[i] = b.bytes_low[8*i +: 8];
        for (int i = 0; i < 7; i++)
            ib[8+i] = b.bytes_high[8*i +: 8];
        for (int i = 0; i < at && i < 15; i++)
            ib[i] = pick_prefix();
        if (at < 15)
            ib[at] = op;
        if (at + 1 < 15)
            ib[at+1] = nxt;
        if (at + 2 < 15)
            ib[at+2] = nxt2;
        for (int i = 0; i < 8; i++)
            b.bytes_low[8*i +: 8] = ib[i];
        for (int i = 0; i < 7; i++)
            b.bytes_high[8*i +: 8] = ib[8+i];
        b.instr_len = 4'(cnt);
        return b;
    endfunction

    function automatic instr_beat_t random_instruction();
        instr_beat_t b;
        int          np;
        int          len;
        int          cnt;
        byte_t       op;
        byte_t       nxt;
        logic [31:0] ft;
        b = rand_fields();
        // some pure noise
        if ($urandom_range(0, 99) < 15)
            return b;
        np = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 14) : $urandom_range(0, 3);
        nxt = byte_t'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: op = byte_t'(OP_JCC_LO + $urandom_range(0, 15));
            1: op = byte_t'(OP_LOOP_LO + $urandom_range(0, 3));
            2: case ($urandom_range(0, 3))
                   0: op = OP_JMP_NEAR;
                   1: op = OP_JMP_FAR;
                   2: op = OP_JMP_SHRT;
                   default: op = OP_GRP5;
               endcase
            3: op = byte_t'(OP_IN_IB + $urandom_range(0, 3));
            4: op = byte_t'(OP_IN_DB + $urandom_range(0, 3));
            5: begin
                op = OP_ESCAPE;
                case ($urandom_range(0, 3))
                    0: nxt = ESC_GRP7;
                    1: nxt = ESC_MOV_RCR;
                    2: nxt = ESC_MOV_CRR;
                    default: nxt = byte_t'($urandom_range(0, 255));
                endcase
            end
            default: op = byte_t'($urandom_range(0, 255));
        endcase
        len = np + 1 + $urandom_range(0, 4);
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : ((len > 15) ? 15 : len);
        b = place(b, np, op, nxt, byte_t'($urandom_range(0, 255)), cnt);
        b.body_length = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
        case ($urandom_range(0, 3))
            0: b.old_ip = 32'h0000_FFF0 + $urandom_range(0, 15);
            1: b.old_ip = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: ;
        endcase
        ft = b.old_ip + 32'(np) + 32'(b.body_length);
        if (!b.old_default_size_32)
            ft[31:16] = '0;
        if ($urandom_range(0, 1))
            b.new_ip = ft;
        else if ($urandom_range(0, 1))
            b.new_ip = ft + $urandom_range(1, 3);
        return b;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_instruction(instr_beat_t b);
        bit quiet;
        quiet = (beats_sent >= 300 && beats_sent < 450);
        while (!quiet && $urandom_range(0, 99) < 31)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        drive_beat <= b;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        checker_h.note_instruction(b);
        beats_sent++;
        @(negedge clk);
    endtask

    // result side: random stalls, one long hold-off, and a stretch with none
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && beats_sent >= 120)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                out_stall <= 1'b0;
            end
            else if (beats_sent >= 450 && beats_sent < 600)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 31);
        end
    end

    initial
    begin
        instr_beat_t b;
        checker_h = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        drive_beat = '0;

        // empty instruction, and all-ones bytes (group 5 with register ModRM)
        b = rand_fields();
        b.bytes_low = '0;
        b.bytes_high = '0;
        b.instr_len = 4'd0;
        stim_q.push_back(b);
        b = rand_fields();
        b.bytes_low = '1;
        b.bytes_high = '1;
        b.instr_len = 4'd15;
        stim_q.push_back(b);
        // nothing but prefixes; escape as the last valid byte
        stim_q.push_back(place(rand_fields(), 15, OP_ESCAPE, 8'h00, 8'h00, 15));
        stim_q.push_back(place(rand_fields(), 14, OP_ESCAPE, ESC_GRP7, 8'h00, 15));
        // escape forms: memory ModRM, ModRM cut off, register ModRM, no ModRM
        stim_q.push_back(place(rand_fields(), 2, OP_ESCAPE, ESC_GRP7, MODRM_MEM_DSP, 5));
        stim_q.push_back(place(rand_fields(), 0, OP_ESCAPE, ESC_MOV_RCR, MODRM_REG_EAX, 2));
        stim_q.push_back(place(rand_fields(), 1, OP_ESCAPE, ESC_MOV_CRR, MODRM_REG_EAX, 4));
        stim_q.push_back(place(rand_fields(), 0, OP_ESCAPE, ESC_CPUID, MODRM_REG_EAX, 3));
        // plain ModRM opcodes, one with the ModRM past the valid bytes
        stim_q.push_back(place(rand_fields(), 0, OP_ADD_EB_GB, MODRM_REG_EAX, 8'h00, 1));
        stim_q.push_back(place(rand_fields(), 0, OP_ALU_LAST, MODRM_REG_EAX, 8'h00, 2));
        stim_q.push_back(place(rand_fields(), 3, OP_POP_EV, MODRM_MEM_DSP, 8'h00, 6));
        // undecodable Jcc
        b = place(rand_fields(), 0, OP_JCC_HI, 8'h00, 8'h00, 2);
        b.body_length = 4'd0;
        stim_q.push_back(b);
        // Jcc fallthrough with 16-bit wrap
        b = place(rand_fields(), 1, OP_JCC_LO, 8'h00, 8'h00, 3);
        b.old_ip = 32'h1234_FFFF;
        b.old_default_size_32 = 1'b0;
        b.body_length = 4'd2;
        b.new_ip = 32'h0000_0002;
        stim_q.push_back(b);
        // JCXZ fallthrough with 32-bit wrap
        b = place(rand_fields(), 0, OP_JCXZ, 8'h00, 8'h00, 2);
        b.old_ip = 32'hFFFF_FFFF;
        b.old_default_size_32 = 1'b1;
        b.body_length = 4'd2;
        b.new_ip = 32'h0000_0001;
        stim_q.push_back(b);
        // LOOP taken
        b = place(rand_fields(), 0, OP_LOOP_LO, 8'h00, 8'h00, 2);
        b.body_length = 4'd2;
        b.new_ip = b.old_ip + 32'd40;
        stim_q.push_back(b);
        stim_q.push_back(place(rand_fields(), 0, OP_JMP_NEAR, 8'h00, 8'h00, 5));
        stim_q.push_back(place(rand_fields(), 1, OP_JMP_FAR, 8'h00, 8'h00, 8));
        stim_q.push_back(place(rand_fields(), 0, OP_JMP_SHRT, 8'h00, 8'h00, 2));
        // IO: port byte missing, then each width and direction
        stim_q.push_back(place(rand_fields(), 0, OP_IN_IB, 8'h00, 8'h00, 1));
        b = place(rand_fields(), 0, OP_IN_IV, 8'hFF, 8'h00, 2);
        b.default_size_32 = 1'b1;
        b.operand_prefix = 1'b0;
        stim_q.push_back(b);
        stim_q.push_back(place(rand_fields(), 1, OP_OUT_IB, 8'h80, 8'h00, 3));
        b = place(rand_fields(), 0, OP_OUT_IV, 8'h00, 8'h00, 2);
        b.default_size_32 = 1'b0;
        b.operand_prefix = 1'b0;
        stim_q.push_back(b);
        stim_q.push_back(place(rand_fields(), 0, OP_IN_DB, 8'h00, 8'h00, 1));
        b = place(rand_fields(), 0, OP_IN_DV, 8'h00, 8'h00, 1);
        b.default_size_32 = 1'b0;
        b.operand_prefix = 1'b1;
        stim_q.push_back(b);
        stim_q.push_back(place(rand_fields(), 2, OP_OUT_DB, 8'h00, 8'h00, 3));
        stim_q.push_back(place(rand_fields(), 0, OP_OUT_DV, 8'h00, 8'h00, 1));

        repeat (NUM_RANDOM) stim_q.push_back(random_instruction());

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_q[i])
            send_instruction(stim_q[i]);
        in_valid <= 1'b0;

        while (checker_h.expected_decodes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (checker_h.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
